/* rtl/gcib_pkg.sv */
// Shared widths, constants and data types for the great-circle bearing pipeline.
package gcib_pkg;

  localparam int ANGLE_BITS_DEF   = 32;
  localparam int HEADING_BITS_DEF = 16;
  localparam int PHASE_W          = 32;
  localparam int CORDIC_STEPS     = 30;
  localparam int FRAC_BITS        = 30;
  localparam int TRIG_W           = 33;
  localparam int Z_W              = 33;
  localparam int VEC_W            = 36;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
  localparam logic [PHASE_W-1:0] PHASE_HALF    = 32'h8000_0000;
  localparam logic [PHASE_W-1:0] PHASE_QUARTER = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] PHASE_3QUARTER = 32'hC000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [0:CORDIC_STEPS-1][PHASE_W-1:0] STEP_ANGLE = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [Z_W-1:0]    z;
  } rot_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [PHASE_W-1:0]      z;
  } vec_t;

endpackage

/* rtl/gcib_rot_stage.sv */
// One registered micro-rotation of the rotation-mode CORDIC (sine/cosine).
module gcib_rot_stage
  import gcib_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  rot_t rot_i,
  output rot_t rot_o
);

  localparam logic signed [Z_W-1:0] ANG = Z_W'(STEP_ANGLE[STEP]);

  logic signed [TRIG_W-1:0] dx, dy;
  rot_t rot_d, rot_q;

  assign dx = rot_i.y >>> STEP;
  assign dy = rot_i.x >>> STEP;

  always_comb begin
    if (!rot_i.z[Z_W-1]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - ANG;
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rot_q <= rot_d;
  end

  assign rot_o = rot_q;

endmodule

/* rtl/gcib_vec_stage.sv */
// One registered micro-rotation of the vectoring-mode CORDIC (atan2).
module gcib_vec_stage
  import gcib_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  vec_t vec_i,
  output vec_t vec_o
);

  localparam logic [PHASE_W-1:0] ANG = STEP_ANGLE[STEP];

  logic signed [VEC_W-1:0] dx, dy;
  vec_t vec_d, vec_q;

  assign dx = vec_i.y >>> STEP;
  assign dy = vec_i.x >>> STEP;

  always_comb begin
    if (!vec_i.y[VEC_W-1]) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + ANG;
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule

/* rtl/great_circle_initial_bearing_unit.sv */
// Top level: pipelined initial great-circle bearing from two lat/lon points.
//
// Input channel: in_valid_i / in_stall_o with from_lat, from_lon, to_lat and
// to_lon as binary angles (2^ANGLE_BITS is one turn). A transaction is taken
// at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with heading_o, an unsigned
// binary angle clockwise from north (2^HEADING_BITS is one turn).
// The path from input transaction to heading_o runs through the two 30-step
// CORDIC pipelines (three sin/cos lanes, then one atan2 lane), plus phase
// preparation, sign restore, two multiplier stages, the subtract, atan2
// preparation and the rounding output register. One transaction enters
// every cycle unless out_stall_i freezes the pipeline.
// While out_stall_i holds a valid result, the whole pipeline freezes and
// in_stall_o is raised; nothing is dropped or repeated.
// Reset clears every valid bit; the datapath needs no reset.
module great_circle_initial_bearing_unit
  import gcib_pkg::*;
#(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int HEADING_BITS = HEADING_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [ANGLE_BITS-1:0]   from_lat_i,
  input  logic signed [ANGLE_BITS-1:0]   from_lon_i,
  input  logic signed [ANGLE_BITS-1:0]   to_lat_i,
  input  logic signed [ANGLE_BITS-1:0]   to_lon_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [HEADING_BITS-1:0]        heading_o
);

  localparam int ROT_END = CORDIC_STEPS;      // last rotation stage
  localparam int FLP_ST  = ROT_END + 1;
  localparam int MUL1_ST = FLP_ST + 1;
  localparam int MUL2_ST = MUL1_ST + 1;
  localparam int DEN_ST  = MUL2_ST + 1;
  localparam int VPR_ST  = DEN_ST + 1;
  localparam int OUT_ST  = VPR_ST + CORDIC_STEPS + 1;
  localparam int NST     = OUT_ST + 1;

  logic en;
  logic [NST-1:0] vld_q;

  assign en          = ~(vld_q[OUT_ST] & out_stall_i);
  assign in_stall_o  = ~en;
  assign out_valid_o = vld_q[OUT_ST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // ---------------- phase reduction and quadrant fold ----------------
  logic [ANGLE_BITS-1:0] dlon;
  logic [2:0][PHASE_W-1:0] phase;
  logic [2:0] flip_d;
  rot_t [2:0] rot_d;

  assign dlon = to_lon_i - from_lon_i;

  if (ANGLE_BITS >= PHASE_W) begin : g_red_hi
    assign phase[0] = from_lat_i[ANGLE_BITS-1 -: PHASE_W];
    assign phase[1] = to_lat_i[ANGLE_BITS-1 -: PHASE_W];
    assign phase[2] = dlon[ANGLE_BITS-1 -: PHASE_W];
  end else begin : g_red_lo
    assign phase[0] = {from_lat_i, {(PHASE_W-ANGLE_BITS){1'b0}}};
    assign phase[1] = {to_lat_i, {(PHASE_W-ANGLE_BITS){1'b0}}};
    assign phase[2] = {dlon, {(PHASE_W-ANGLE_BITS){1'b0}}};
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      flip_d[l]  = (phase[l][PHASE_W-1] ^ phase[l][PHASE_W-2]);
      rot_d[l].x = CORDIC_GAIN;
      rot_d[l].y = '0;
      // fold into [-90, 90) by turning half a turn
      rot_d[l].z = Z_W'($signed(phase[l] ^ (flip_d[l] ? PHASE_HALF : '0)));
    end
  end

  // ---------------- sine/cosine CORDIC lanes ----------------
  rot_t [2:0] rot0_q;
  rot_t [2:0] rot_pipe [0:CORDIC_STEPS];
  logic [2:0] flip_q [0:CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot0_q    <= rot_d;
      flip_q[0] <= flip_d;
      for (int k = 1; k <= CORDIC_STEPS; k++) flip_q[k] <= flip_q[k-1];
    end
  end

  assign rot_pipe[0] = rot0_q;

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_rot
    for (genvar l = 0; l < 3; l++) begin : g_lane
      gcib_rot_stage #(.STEP(s)) u_rot (
        .clk_i (clk_i),
        .en_i  (en),
        .rot_i (rot_pipe[s][l]),
        .rot_o (rot_pipe[s+1][l])
      );
    end
  end

  // ---------------- sign restore ----------------
  logic signed [TRIG_W-1:0] c1_q, s1_q, c2_q, s2_q, cd_q, sd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= flip_q[CORDIC_STEPS][0] ? -rot_pipe[CORDIC_STEPS][0].x : rot_pipe[CORDIC_STEPS][0].x;
      s1_q <= flip_q[CORDIC_STEPS][0] ? -rot_pipe[CORDIC_STEPS][0].y : rot_pipe[CORDIC_STEPS][0].y;
      c2_q <= flip_q[CORDIC_STEPS][1] ? -rot_pipe[CORDIC_STEPS][1].x : rot_pipe[CORDIC_STEPS][1].x;
      s2_q <= flip_q[CORDIC_STEPS][1] ? -rot_pipe[CORDIC_STEPS][1].y : rot_pipe[CORDIC_STEPS][1].y;
      cd_q <= flip_q[CORDIC_STEPS][2] ? -rot_pipe[CORDIC_STEPS][2].x : rot_pipe[CORDIC_STEPS][2].x;
      sd_q <= flip_q[CORDIC_STEPS][2] ? -rot_pipe[CORDIC_STEPS][2].y : rot_pipe[CORDIC_STEPS][2].y;
    end
  end

  // ---------------- products ----------------
  logic signed [2*TRIG_W-1:0] p_num, p_t, p_cs, p_tc;
  logic signed [2*TRIG_W-1:0] sh_num, sh_t, sh_cs, sh_tc;
  logic signed [TRIG_W-1:0] num1_q, t_q, cs_q, cd1_q;
  logic signed [TRIG_W-1:0] num2_q, cs2_q, tc_q;

  assign p_num  = sd_q * c2_q;
  assign p_t    = s1_q * c2_q;
  assign p_cs   = c1_q * s2_q;
  assign sh_num = p_num >>> FRAC_BITS;
  assign sh_t   = p_t >>> FRAC_BITS;
  assign sh_cs  = p_cs >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q <= sh_num[TRIG_W-1:0];
      t_q    <= sh_t[TRIG_W-1:0];
      cs_q   <= sh_cs[TRIG_W-1:0];
      cd1_q  <= cd_q;
    end
  end

  assign p_tc  = t_q * cd1_q;
  assign sh_tc = p_tc >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num2_q <= num1_q;
      cs2_q  <= cs_q;
      tc_q   <= sh_tc[TRIG_W-1:0];
    end
  end

  // ---------------- difference ----------------
  logic signed [VEC_W-1:0] num_q, den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= {{(VEC_W-TRIG_W){num2_q[TRIG_W-1]}}, num2_q};
      den_q <= {{(VEC_W-TRIG_W){cs2_q[TRIG_W-1]}}, cs2_q}
             - {{(VEC_W-TRIG_W){tc_q[TRIG_W-1]}}, tc_q};
    end
  end

  // ---------------- atan2 preparation ----------------
  vec_t vec0_q;
  vec_t vec_pipe [0:CORDIC_STEPS];
  logic spec_q [0:CORDIC_STEPS];
  logic [PHASE_W-1:0] sval_q [0:CORDIC_STEPS];
  vec_t vec_d;
  logic spec_d;
  logic [PHASE_W-1:0] sval_d;

  always_comb begin
    spec_d = 1'b0;
    sval_d = '0;
    if (num_q == '0) begin
      spec_d = 1'b1;
      sval_d = den_q[VEC_W-1] ? PHASE_HALF : '0;
    end else if (den_q == '0) begin
      spec_d = 1'b1;
      sval_d = num_q[VEC_W-1] ? PHASE_3QUARTER : PHASE_QUARTER;
    end
    if (den_q[VEC_W-1]) begin
      vec_d.x = -den_q;
      vec_d.y = -num_q;
      vec_d.z = PHASE_HALF;
    end else begin
      vec_d.x = den_q;
      vec_d.y = num_q;
      vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec0_q    <= vec_d;
      spec_q[0] <= spec_d;
      sval_q[0] <= sval_d;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        spec_q[k] <= spec_q[k-1];
        sval_q[k] <= sval_q[k-1];
      end
    end
  end

  assign vec_pipe[0] = vec0_q;

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_vec
    gcib_vec_stage #(.STEP(s)) u_vec (
      .clk_i (clk_i),
      .en_i  (en),
      .vec_i (vec_pipe[s]),
      .vec_o (vec_pipe[s+1])
    );
  end

  // ---------------- rounding and output ----------------
  logic [PHASE_W-1:0] bearing;
  logic [HEADING_BITS-1:0] heading_d, heading_q;

  assign bearing = spec_q[CORDIC_STEPS] ? sval_q[CORDIC_STEPS] : vec_pipe[CORDIC_STEPS].z;

  if (HEADING_BITS < PHASE_W) begin : g_round
    logic [PHASE_W-1:0] rsum;
    assign rsum      = bearing + (PHASE_W'(1) << (PHASE_W - HEADING_BITS - 1));
    assign heading_d = rsum[PHASE_W-1 -: HEADING_BITS];
  end else begin : g_noround
    assign heading_d = bearing[PHASE_W-1 -: HEADING_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en) heading_q <= heading_d;
  end

  assign heading_o = heading_q;

endmodule

/* bench/gcib_checker.sv */
// Bearing checker: watches both channels, predicts headings and compares them.
`timescale 1ns / 100ps
module gcib_checker
  import gcib_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] from_lat_i,
  input  logic [31:0] from_lon_i,
  input  logic [31:0] to_lat_i,
  input  logic [31:0] to_lon_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] heading_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [15:0] heading_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void rotate_phase(input logic [31:0] phase,
                                       output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    if (phase >= PHASE_QUARTER && phase < PHASE_3QUARTER) begin
      phase = phase - PHASE_HALF;
      flip = 1;
    end
    z = longint'($signed(phase));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(STEP_ANGLE[i]);
      end else begin
        x += dx; y -= dy; z += longint'(STEP_ANGLE[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] vector_angle(longint num, longint den);
    longint x, y, z, dx, dy;
    if (num == 0) return (den < 0) ? PHASE_HALF : 32'd0;
    if (den == 0) return (num > 0) ? PHASE_QUARTER : PHASE_3QUARTER;
    if (den < 0) begin
      x = -den; y = -num; z = longint'(PHASE_HALF);
    end else begin
      x = den; y = num; z = 0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(STEP_ANGLE[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(STEP_ANGLE[i]);
      end
    end
    return z[31:0];
  endfunction

  function automatic logic [15:0] bearing_of(logic [31:0] lat1, logic [31:0] lon1,
                                             logic [31:0] lat2, logic [31:0] lon2);
    longint c1, s1, c2, s2, cd, sd, num, den, t;
    logic [32:0] h;
    rotate_phase(lat1, c1, s1);
    rotate_phase(lat2, c2, s2);
    rotate_phase(lon2 - lon1, cd, sd);
    num = floor_shr(sd * c2, 30);
    t = floor_shr(s1 * c2, 30);
    den = floor_shr(c1 * s2, 30) - floor_shr(t * cd, 30);
    h = {1'b0, vector_angle(num, den)} + 33'h8000;
    return h[31:16];
  endfunction

  assign pending_o = heading_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        heading_q.push_back(bearing_of(from_lat_i, from_lon_i, to_lat_i, to_lon_i));
      if (out_valid_i && !out_stall_i) begin
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected heading %h", $time, heading_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = heading_q.pop_front();
          if (want !== heading_i) begin
            $display("%0t: heading expected %h actual %h", $time, want, heading_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/tb.sv */
// Testbench top: drives point pairs into the bearing unit and reports the verdict.
`timescale 1ns / 100ps
module tb;
  localparam int LATENCY = 67;
  localparam longint CYCLE_LIMIT = 200000;
  localparam logic [31:0] LAT_MAX = 32'h4000_0000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [31:0] from_lat_i, from_lon_i, to_lat_i, to_lon_i;
  logic [15:0] heading_o;
  int          fail_count, pending;
  longint      cycle_count;
  bit          calm;

  great_circle_initial_bearing_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .from_lat_i, .from_lon_i, .to_lat_i, .to_lon_i,
    .out_valid_o, .out_stall_i, .heading_o
  );

  gcib_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .from_lat_i, .from_lon_i, .to_lat_i, .to_lon_i,
    .out_valid_i(out_valid_o), .out_stall_i, .heading_i(heading_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[great_circle_initial_bearing_unit] ERROR");
      $finish;
    end
  end

  // stall the result channel at random, except in the calm stretch
  always @(posedge clk_i)
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 37);

  function automatic logic [31:0] any_lat();
    case ($urandom_range(5))
      0: return LAT_MAX;
      1: return -LAT_MAX;
      2: return $urandom();
      default: return 32'($signed($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
    endcase
  endfunction

  task automatic send(logic [31:0] lat1, logic [31:0] lon1,
                      logic [31:0] lat2, logic [31:0] lon2);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    from_lat_i <= lat1; from_lon_i <= lon1;
    to_lat_i <= lat2; to_lon_i <= lon2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] lat, lon;
    cycle_count = 0;
    calm = 0;
    in_valid_i = 0;
    out_stall_i = 0;
    {from_lat_i, from_lon_i, to_lat_i, to_lon_i} = '0;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: poles, identical points, antimeridian, extremes
    send(0, 0, 0, 0);
    send(LAT_MAX, 0, LAT_MAX, 0);
    send(-LAT_MAX, 0, LAT_MAX, 0);
    send(LAT_MAX, 0, 0, 32'h1234_5678);
    send(0, 0, 0, 32'h4000_0000);
    send(0, 0, 0, 32'hC000_0000);
    send(0, 0, 32'h1000_0000, 0);
    send(0, 0, -32'h1000_0000, 0);
    send(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
    send(0, 32'h7FFF_FFFF, 0, 32'h8000_0000);
    send(0, 0, 0, 32'h8000_0000);
    send(32'h1000_0000, 32'h8000_0000, 32'h2000_0000, 32'h7FFF_FFFF);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h0000_0001);
    send(LAT_MAX - 1, 5, -LAT_MAX + 1, 32'h8000_0005);
    send(32'h2AAA_AAAA, 32'h5555_5555, 32'hD555_5556, 32'hAAAA_AAAA);
    for (int i = 0; i < 650; i++) begin
      if (i == 200) begin
        in_valid_i <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end
      calm = (i >= 350 && i < 450);
      lat = any_lat();
      lon = $urandom();
      case ($urandom_range(4))
        0: send(lat, lon, lat, lon);
        1: send(lat, lon, any_lat(), lon + 32'($urandom_range(15)) - 8);
        2: send(lat, lon, -lat, lon ^ 32'h8000_0000);
        default: send(lat, lon, any_lat(), $urandom());
      endcase
    end
    calm = 0;
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0)
      $display("[great_circle_initial_bearing_unit] OK");
    else
      $display("[great_circle_initial_bearing_unit] ERROR");
    $finish;
  end
endmodule
